[hw/rtl/utf8dec_pkg.sv]
// Package for the UTF-8 byte stream decoder.
// Holds the result status codes, the result word type and the field widths.
// No dependencies.
package utf8dec_pkg;

  localparam int CpW    = 21;
  localparam int StW    = 2;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  // Result status codes
  localparam logic [StW-1:0] ST_CHAR    = 2'd0;
  localparam logic [StW-1:0] ST_PROBLEM = 2'd1;
  localparam logic [StW-1:0] ST_END     = 2'd2;

  // One result word
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic [StW-1:0] status;
    logic           run_last;
  } res_t;

endpackage

[hw/rtl/utf8_byte_stream_decoder.sv]
// An accepted input word is held in the input register, then decoded into the result queue.
// Throughput: one byte per cycle while the queue has room for two; a byte that ends a
//   buffer on a whole character yields two results, absorbed by a 4-entry result queue.
// Decode takes a byte from the input register only while the queue has room for two.
// Reset (rst_n low, synchronous) empties the input register and queue and clears the
//   sequence state: no partial value, no bytes expected, not discarding.
// Top level of the UTF-8 byte stream decoder: input register, decode, result queue.
// Depends on utf8dec_pkg.
module utf8_byte_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // run_last
);

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_fin_r;

  // Sequence state
  logic [utf8dec_pkg::CpW-1:0] partial_r, partial_nxt;
  logic [1:0]                  rem_r, rem_nxt;
  logic                        disc_r, disc_nxt;

  // Result queue
  utf8dec_pkg::res_t                q_mem_r [utf8dec_pkg::QDepth];
  logic [utf8dec_pkg::QPtrW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [utf8dec_pkg::QCntW-1:0]    cnt_r;

  logic              dec_fire;
  logic              pop;
  logic [1:0]        n_push;
  utf8dec_pkg::res_t res0, res1;
  logic [utf8dec_pkg::CpW-1:0] pv;
  logic              have_char;
  logic              bad_lead;
  logic [utf8dec_pkg::CpW-1:0] cp;

  // Decode when a byte is held and the queue can take two results
  assign dec_fire  = in_vld_r && (cnt_r <= utf8dec_pkg::QCntW'(utf8dec_pkg::QDepth - 2));
  assign in_tready = !in_vld_r || dec_fire;
  assign pop       = out_tvalid && out_tready;

  // Hold the incoming word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_fin_r  <= in_tlast;
    end
  end

  // Decode one byte against the sequence state
  always_comb begin
    partial_nxt = partial_r;
    rem_nxt     = rem_r;
    disc_nxt    = disc_r;
    n_push      = 2'd0;
    res0        = '0;
    res1        = '0;
    have_char   = 1'b0;
    bad_lead    = 1'b0;
    cp          = '0;
    pv          = {partial_r[utf8dec_pkg::CpW-7:0], in_byte_r[5:0]};
    if (disc_r) begin
      // drop bytes until the buffer ends
      if (in_fin_r) begin
        disc_nxt = 1'b0;
      end
    end else begin
      if (rem_r != 2'd0) begin
        rem_nxt = rem_r - 2'd1;
        if (rem_r == 2'd1) begin
          have_char   = 1'b1;
          cp          = pv;
          partial_nxt = '0;
        end else begin
          partial_nxt = pv;
        end
      end else if (!in_byte_r[7]) begin
        have_char = 1'b1;
        cp        = {13'd0, in_byte_r};
      end else if (in_byte_r[7:5] == 3'b110) begin
        partial_nxt = {16'd0, in_byte_r[4:0]};
        rem_nxt     = 2'd1;
      end else if (in_byte_r[7:4] == 4'b1110) begin
        partial_nxt = {17'd0, in_byte_r[3:0]};
        rem_nxt     = 2'd2;
      end else if (in_byte_r[7:3] == 5'b11110) begin
        partial_nxt = {18'd0, in_byte_r[2:0]};
        rem_nxt     = 2'd3;
      end else begin
        // invalid lead: report and discard the rest of the buffer
        bad_lead    = 1'b1;
        partial_nxt = '0;
        rem_nxt     = 2'd0;
        disc_nxt    = !in_fin_r;
        res0        = '{code_point: '0, status: utf8dec_pkg::ST_PROBLEM, run_last: 1'b1};
        n_push      = 2'd1;
      end
      if (!bad_lead) begin
        if (have_char) begin
          res0   = '{code_point: cp, status: utf8dec_pkg::ST_CHAR, run_last: !in_fin_r};
          n_push = 2'd1;
          if (in_fin_r) begin
            res1   = '{code_point: '0, status: utf8dec_pkg::ST_END, run_last: 1'b1};
            n_push = 2'd2;
          end
        end else if (in_fin_r) begin
          // buffer ended inside a sequence
          partial_nxt = '0;
          rem_nxt     = 2'd0;
          res0   = '{code_point: '0, status: utf8dec_pkg::ST_PROBLEM, run_last: 1'b1};
          n_push = 2'd1;
        end
      end
    end
  end

  // Advance the sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      rem_r     <= 2'd0;
      disc_r    <= 1'b0;
    end else if (dec_fire) begin
      partial_r <= partial_nxt;
      rem_r     <= rem_nxt;
      disc_r    <= disc_nxt;
    end
  end

  // Write results into the queue
  always_ff @(posedge clk) begin
    if (dec_fire && (n_push != 2'd0)) begin
      q_mem_r[wr_ptr_r] <= res0;
    end
    if (dec_fire && (n_push == 2'd2)) begin
      q_mem_r[wr_ptr_r + utf8dec_pkg::QPtrW'(1)] <= res1;
    end
  end

  // Track queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (dec_fire) begin
        wr_ptr_r <= wr_ptr_r + utf8dec_pkg::QPtrW'(n_push);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + utf8dec_pkg::QPtrW'(1);
      end
      cnt_r <= cnt_r + (dec_fire ? utf8dec_pkg::QCntW'(n_push) : '0)
                     - utf8dec_pkg::QCntW'(pop);
    end
  end

  // Present the queue head
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {3'd0, q_mem_r[rd_ptr_r].code_point};
  assign out_tuser  = q_mem_r[rd_ptr_r].status;
  assign out_tlast  = q_mem_r[rd_ptr_r].run_last;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= utf8dec_pkg::QCntW'(utf8dec_pkg::QDepth))
    else $error("result queue overfilled");

  a_disc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (rem_r == 2'd0) && (partial_r == '0))
    else $error("sequence state left open while discarding");

  a_noncar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != utf8dec_pkg::ST_CHAR) |-> (out_tdata == '0) && out_tlast)
    else $error("problem or end result carries a code point or is not last");

  a_two_push: assert property (@(posedge clk) disable iff (!rst_n)
    dec_fire && (n_push == 2'd2) |=> cnt_r != '0)
    else $error("two results pushed but queue empty");

endmodule
